// ===== src/dlt_pkg.sv =====
// Package for the delta list timer queue.
// Holds sizing constants, request/response structs and command codes.
// No dependencies.
package dlt_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned TICK_MS   = 10;

  // Slot pointers are 5 bits wide; all ones means no slot.
  localparam int unsigned SlotW    = 5;
  localparam int unsigned SlotIdxW = $clog2(NUM_SLOTS);
  localparam logic [SlotW-1:0] SlotNil = '1;

  localparam int unsigned MsW  = 16;
  localparam int unsigned IdW  = 8;

  // Divide by the tick length as a multiply by a rounded-up reciprocal and a
  // right shift; exact for every MsW-bit dividend.
  localparam int unsigned DivShift = MsW + $clog2(TICK_MS);
  localparam int unsigned ProdW    = DivShift + MsW;
  localparam logic [MsW:0] DivRecip =
    (MsW+1)'(((64'd1 << DivShift) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

  localparam logic [IdW-1:0] IdFirst = IdW'(1);
  localparam logic [IdW-1:0] IdLast  = '1;

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdSet   = 2'd1,
    CmdClear = 2'd2,
    CmdNop   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]     cmd;
    logic [MsW-1:0] delay_ms;
    logic [MsW-1:0] period_ms;
  } in_req_t;

  typedef struct packed {
    logic [IdW-1:0] new_id;
    logic [IdW-1:0] expired_id;
  } out_rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/dlt_div.sv =====
// Divider by the tick length: reciprocal multiply that latches the operand, then registers the quotient.
// Depends on dlt_pkg.
module dlt_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dlt_pkg::MsW-1:0]   dividend_i,
  output dlt_pkg::div_stat_t        stat_o,
  output logic [dlt_pkg::MsW-1:0]   quot_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [dlt_pkg::MsW-1:0]     num_q, num_d;
  logic [dlt_pkg::MsW-1:0]     quot_q, quot_d;
  logic [dlt_pkg::ProdW-1:0]   prod;

  // Latch the operand, then take the high bits of the scaled product
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    num_d  = num_q;
    quot_d = quot_q;
    prod   = num_q * dlt_pkg::DivRecip;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      num_d  = dividend_i;
    end else if (busy_q) begin
      quot_d = prod[dlt_pkg::ProdW-1 -: dlt_pkg::MsW];
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q) else $error("divider done without run");
`endif

endmodule

// ===== src/delta_list_timer_queue_top.sv =====
// Top level of the delta list timer queue: slot store, list sequencer, output register.
// Depends on dlt_pkg and dlt_div.
//
// Usage:
//   Requests enter on in_req_i under in_valid_i/in_stall_o. A request is taken
//   at an edge where valid is high and stall is low; stall stays high while a
//   request is being worked. Each request gives one response on out_rsp_o
//   under out_valid_o/out_stall_i: the new id from an accepted set (0 otherwise) and the
//   current expiry flag.
//   A set runs the shared divider twice, delay then period, and then walks the
//   list one slot per cycle to find its place; a periodic clear walks the list
//   likewise to reinsert its head. Ticks, one-shot clears, no-ops, null or
//   full sets and clears of an empty list use neither the divider nor the walk.
//   Reset: the list is empty, all slots are free, the next id is 1 and the
//   flag is 0. While the receiver stalls, the finished response is held and
//   one more request may be taken; it completes once the output frees.
module delta_list_timer_queue_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dlt_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dlt_pkg::out_rsp_t out_rsp_o
);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StTick  = 9'b000000010,
    StDivD  = 9'b000000100,
    StDivP  = 9'b000001000,
    StWalk  = 9'b000010000,
    StClr   = 9'b000100000,
    StChk   = 9'b001000000,
    StDone  = 9'b010000000,
    StWaitD = 9'b100000000
  } state_e;

  localparam int unsigned SW = dlt_pkg::SlotW;
  localparam int unsigned MW = dlt_pkg::MsW;
  localparam int unsigned IW = dlt_pkg::IdW;
  localparam int unsigned XW = dlt_pkg::SlotIdxW;

  state_e state_q, state_d;

  // Slot store
  logic [IW-1:0] id_q   [dlt_pkg::NUM_SLOTS];
  logic [MW-1:0] cd_q   [dlt_pkg::NUM_SLOTS];
  logic [MW-1:0] per_q  [dlt_pkg::NUM_SLOTS];
  logic [SW-1:0] link_q [dlt_pkg::NUM_SLOTS];

  logic [SW-1:0] head_q, head_d, free_q, free_d;
  logic [SW-1:0] cur_q, cur_d, prev_q, prev_d, ins_q, ins_d;
  logic [MW-1:0] acc_q, acc_d;
  logic [IW-1:0] seed_q, seed_d, flag_q, flag_d, nid_q, nid_d;
  logic [1:0]    cmd_q, cmd_d;
  logic [MW-1:0] per_ms_q, per_ms_d;
  logic          out_valid_q, out_valid_d;
  dlt_pkg::out_rsp_t out_q, out_d;

  // Shared divider
  logic               div_start;
  logic [MW-1:0]      div_num, div_quot;
  dlt_pkg::div_stat_t div_stat;

  // Single read port into the slot store
  logic [SW-1:0] rd_slot;
  logic [XW-1:0] rd_idx;
  logic [MW-1:0] rd_cd, rd_per;
  logic [SW-1:0] rd_link;
  logic [IW-1:0] rd_id;

  // Write ports
  logic          cda_we, cdb_we, lka_we, lkb_we, idw_we, pw_we;
  logic [SW-1:0] cda_slot, cdb_slot, lka_slot, lkb_slot, idw_slot;
  logic [MW-1:0] cda_val, cdb_val, pw_val;
  logic [SW-1:0] lka_val, lkb_val;

  function automatic logic slot_ok(logic [SW-1:0] s);
    return s < SW'(dlt_pkg::NUM_SLOTS);
  endfunction

  dlt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .stat_o    (div_stat),
    .quot_o    (div_quot)
  );

  // Pick the read address for the current step
  always_comb begin
    case (state_q)
      StWalk:  rd_slot = cur_q;
      StDivP:  rd_slot = free_q;
      default: rd_slot = head_q;
    endcase
  end

  assign rd_idx  = rd_slot[XW-1:0];
  assign rd_cd   = cd_q[rd_idx];
  assign rd_per  = per_q[rd_idx];
  assign rd_link = link_q[rd_idx];
  assign rd_id   = id_q[rd_idx];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    free_d      = free_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    ins_d       = ins_q;
    acc_d       = acc_q;
    seed_d      = seed_q;
    flag_d      = flag_q;
    nid_d       = nid_q;
    cmd_d       = cmd_q;
    per_ms_d    = per_ms_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_start   = 1'b0;
    div_num     = per_ms_q;
    cda_we = 1'b0; cda_slot = cur_q;  cda_val = '0;
    cdb_we = 1'b0; cdb_slot = ins_q;  cdb_val = acc_q;
    lka_we = 1'b0; lka_slot = ins_q;  lka_val = cur_q;
    lkb_we = 1'b0; lkb_slot = prev_q; lkb_val = ins_q;
    idw_we = 1'b0; idw_slot = free_q;
    pw_we  = 1'b0; pw_val   = div_quot;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_d    = in_req_i.cmd;
          per_ms_d = in_req_i.period_ms;
          nid_d    = '0;
          case (in_req_i.cmd)
            dlt_pkg::CmdTick: state_d = StTick;
            dlt_pkg::CmdSet: begin
              if ((in_req_i.delay_ms == '0 && in_req_i.period_ms == '0) ||
                  !slot_ok(free_q)) begin
                state_d = StDone;
              end else begin
                div_start = 1'b1;
                div_num   = in_req_i.delay_ms;
                state_d   = StWaitD;
              end
            end
            dlt_pkg::CmdClear: begin
              flag_d  = '0;
              state_d = slot_ok(head_q) ? StClr : StDone;
            end
            default: state_d = StDone;
          endcase
        end
      end
      StWaitD: state_d = StDivD;
      StDivD: begin
        // Hold the delay ticks, at least one, then divide the period
        if (div_stat.done) begin
          acc_d     = (div_quot == '0) ? MW'(1) : div_quot;
          div_start = 1'b1;
          state_d   = StDivP;
        end
      end
      StDivP: begin
        // Take the free head slot and start the ordered insert
        if (div_stat.done) begin
          pw_we    = 1'b1;
          idw_we   = 1'b1;
          free_d   = rd_link;
          ins_d    = free_q;
          nid_d    = seed_q;
          seed_d   = (seed_q == dlt_pkg::IdLast) ? dlt_pkg::IdFirst : seed_q + 1'b1;
          prev_d   = dlt_pkg::SlotNil;
          cur_d    = head_q;
          state_d  = StWalk;
        end
      end
      StWalk: begin
        if (slot_ok(cur_q) && acc_q >= rd_cd) begin
          acc_d  = acc_q - rd_cd;
          prev_d = cur_q;
          cur_d  = rd_link;
        end else begin
          // Link the slot in ahead of cur and trim cur's delta
          cda_we  = slot_ok(cur_q);
          cda_val = rd_cd - acc_q;
          cdb_we  = 1'b1;
          lka_we  = 1'b1;
          lka_val = slot_ok(cur_q) ? cur_q : dlt_pkg::SlotNil;
          if (slot_ok(prev_q)) lkb_we = 1'b1;
          else                 head_d = ins_q;
          state_d = (cmd_q == dlt_pkg::CmdClear) ? StChk : StDone;
        end
      end
      StTick: begin
        // Count down an unexpired head and raise the flag at zero
        if (slot_ok(head_q) && rd_cd != '0) begin
          cda_we   = 1'b1;
          cda_slot = head_q;
          cda_val  = rd_cd - 1'b1;
          if (rd_cd == MW'(1)) flag_d = rd_id;
        end
        state_d = StDone;
      end
      StClr: begin
        // Drop the head; reload a periodic one, free a one-shot one
        head_d = rd_link;
        if (rd_per != '0) begin
          ins_d   = head_q;
          acc_d   = rd_per;
          prev_d  = dlt_pkg::SlotNil;
          cur_d   = rd_link;
          state_d = StWalk;
        end else begin
          lka_we   = 1'b1;
          lka_slot = head_q;
          lka_val  = free_q;
          free_d   = head_q;
          state_d  = StChk;
        end
      end
      StChk: begin
        if (slot_ok(head_q) && rd_cd == '0) flag_d = rd_id;
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.new_id     = nid_q;
          out_d.expired_id = flag_q;
          state_d          = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= dlt_pkg::SlotNil;
      free_q      <= '0;
      seed_q      <= dlt_pkg::IdFirst;
      flag_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < int'(dlt_pkg::NUM_SLOTS); i++) begin
        link_q[i] <= (i + 1 < int'(dlt_pkg::NUM_SLOTS)) ? SW'(i + 1) : dlt_pkg::SlotNil;
      end
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      free_q      <= free_d;
      seed_q      <= seed_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
      if (lka_we) link_q[lka_slot[XW-1:0]] <= lka_val;
      if (lkb_we) link_q[lkb_slot[XW-1:0]] <= lkb_val;
    end
  end

  // Payload registers and slot fields
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    ins_q    <= ins_d;
    acc_q    <= acc_d;
    nid_q    <= nid_d;
    cmd_q    <= cmd_d;
    per_ms_q <= per_ms_d;
    out_q    <= out_d;
    if (cda_we) cd_q[cda_slot[XW-1:0]] <= cda_val;
    if (cdb_we) cd_q[cdb_slot[XW-1:0]] <= cdb_val;
    if (idw_we) id_q[idw_slot[XW-1:0]] <= seed_q;
    if (pw_we)  per_q[idw_slot[XW-1:0]] <= pw_val;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTH
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StDone) else $error("response outside done");
  a_lists_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(slot_ok(head_q) && head_q == free_q)) else $error("slot on both lists");
  a_seed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_q != '0) else $error("id seed is zero");
`endif

endmodule
